/* sv/batched_publish_packet_ring_assert.svh */
`ifndef BATCHED_PUBLISH_PACKET_RING_ASSERT_SVH
`define BATCHED_PUBLISH_PACKET_RING_ASSERT_SVH

// same-cycle implication
`define BPR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring assertion failed");

// next-cycle implication
`define BPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring assertion failed");

`endif

/* sv/bpr_pkg.sv */
package bpr_pkg;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned WORDS_PER_SLOT = 32;
  localparam int unsigned SLOT_W         = $clog2(SLOTS);
  localparam int unsigned WIDX_W         = $clog2(WORDS_PER_SLOT) + 1;
  localparam int unsigned RIDX_W         = $clog2(WORDS_PER_SLOT);
  localparam int unsigned ADDR_W         = $clog2(SLOTS * WORDS_PER_SLOT);
  localparam int unsigned MAX_BYTES      = 8 * WORDS_PER_SLOT;
  localparam int unsigned LEN_W          = 9;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned TS_W           = 52;
  localparam int unsigned BATCH_W        = 4;
  localparam int unsigned PADDR_W        = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

  localparam logic REG_BATCH_SIZE = 1'b0;
  localparam logic [BATCH_W-1:0] BATCH_SIZE_RESET = 4'd1;

  typedef struct packed {
    logic        operation;
    logic [63:0] data_word;
    logic        word_last;
    logic [8:0]  byte_count;
    logic [31:0] ts_seconds;
    logic [19:0] ts_microseconds;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic        read_last;
    logic [8:0]  read_byte_count;
    logic [31:0] read_ts_seconds;
    logic [19:0] read_ts_microseconds;
    logic [31:0] latest_ts_seconds;
    logic [19:0] latest_ts_microseconds;
  } result_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } bpr_cmd_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

/* sv/bpr_stream_if.sv */
interface bpr_in_if import bpr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] data_word;
  logic        word_last;
  logic [LEN_W-1:0] byte_count;
  logic [31:0] ts_seconds;
  logic [19:0] ts_microseconds;

  modport source (
    output valid, operation, data_word, word_last, byte_count, ts_seconds, ts_microseconds,
    input  ready
  );
  modport sink (
    input  valid, operation, data_word, word_last, byte_count, ts_seconds, ts_microseconds,
    output ready
  );
endinterface

interface bpr_out_if import bpr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] read_word;
  logic        read_last;
  logic [LEN_W-1:0] read_byte_count;
  logic [31:0] read_ts_seconds;
  logic [19:0] read_ts_microseconds;
  logic [31:0] latest_ts_seconds;
  logic [19:0] latest_ts_microseconds;

  modport source (
    output valid, status, read_word, read_last, read_byte_count, read_ts_seconds,
           read_ts_microseconds, latest_ts_seconds, latest_ts_microseconds,
    input  ready
  );
  modport sink (
    input  valid, status, read_word, read_last, read_byte_count, read_ts_seconds,
           read_ts_microseconds, latest_ts_seconds, latest_ts_microseconds,
    output ready
  );
endinterface

/* sv/bpr_ctrl.sv */
module bpr_ctrl import bpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output bpr_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.execute = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.execute) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* sv/bpr_datapath.sv */
module bpr_datapath import bpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpr_cmd_t           cmd_i,
  input  logic [BATCH_W-1:0] batch_size_i,
  input  item_t              item_i,
  output result_t            result_o
);

  logic [63:0] payload_mem [SLOTS*WORDS_PER_SLOT];
  logic [LEN_W-1:0] slot_len_q [SLOTS];
  logic [TS_W-1:0]  slot_ts_q [SLOTS];

  item_t   item_q;
  result_t result_q, result_d;
  logic [63:0] rdata_q;

  logic [SLOT_W-1:0]  writer_slot_q, pub_writer_q, reader_slot_q, pub_reader_q;
  logic [BATCH_W-1:0] wbc_q, rbc_q;
  logic [WIDX_W-1:0]  wwi_q;
  logic [RIDX_W-1:0]  rwi_q;
  logic [TS_W-1:0]    latest_q;

  logic              is_write, overflow, full, bad_len, commit, w_publish;
  logic              empty, do_read, rlast, r_publish;
  logic [SLOT_W-1:0] ws_next, rs_next;
  logic [CNT_W-1:0]  words_need, words_have, rwords, ridx_inc;
  logic [LEN_W:0]    len_round, rlen_round;
  logic [LEN_W-1:0]  rlen;
  logic [BATCH_W:0]  wbc_inc, rbc_inc;
  logic [TS_W-1:0]   ts_in, rts;
  logic [ADDR_W-1:0] waddr, raddr;

  always_comb begin
    is_write   = (item_q.operation == OP_WRITE);
    overflow   = (wwi_q >= WIDX_W'(WORDS_PER_SLOT));
    ws_next    = next_slot(writer_slot_q);
    full       = (ws_next == pub_reader_q);
    len_round  = {1'b0, item_q.byte_count} + (LEN_W+1)'(7);
    words_need = CNT_W'(len_round >> 3);
    words_have = CNT_W'(wwi_q) + CNT_W'(1);
    bad_len    = overflow || (item_q.byte_count == '0) ||
                 ({1'b0, item_q.byte_count} > (LEN_W+1)'(MAX_BYTES)) ||
                 (words_need != words_have);
    commit     = is_write && item_q.word_last && !full && !bad_len;
    ts_in      = {item_q.ts_seconds, item_q.ts_microseconds};
    wbc_inc    = {1'b0, wbc_q} + (BATCH_W+1)'(1);
    w_publish  = (wbc_inc >= {1'b0, batch_size_i});

    empty      = (reader_slot_q == pub_writer_q);
    do_read    = !is_write && !empty;
    rs_next    = next_slot(reader_slot_q);
    rlen       = slot_len_q[reader_slot_q];
    rts        = slot_ts_q[reader_slot_q];
    rlen_round = {1'b0, rlen} + (LEN_W+1)'(7);
    rwords     = CNT_W'(rlen_round >> 3);
    if (rwords == '0) begin
      rwords = CNT_W'(1);
    end
    ridx_inc   = CNT_W'(rwi_q) + CNT_W'(1);
    rlast      = (ridx_inc >= rwords);
    rbc_inc    = {1'b0, rbc_q} + (BATCH_W+1)'(1);
    r_publish  = (rbc_inc > {1'b0, batch_size_i});

    waddr = ADDR_W'(writer_slot_q) * ADDR_W'(WORDS_PER_SLOT) + ADDR_W'(wwi_q[RIDX_W-1:0]);
    raddr = ADDR_W'(reader_slot_q) * ADDR_W'(WORDS_PER_SLOT) + ADDR_W'(rwi_q);

    result_d = '0;
    if (is_write) begin
      if (item_q.word_last && full) begin
        result_d.status = STATUS_FULL;
      end else if (item_q.word_last && bad_len) begin
        result_d.status = STATUS_BAD_LEN;
      end else begin
        result_d.status = STATUS_OK;
      end
    end else if (empty) begin
      result_d.status = STATUS_EMPTY;
    end else begin
      result_d.status               = STATUS_OK;
      result_d.read_word            = rdata_q;
      result_d.read_last            = rlast;
      result_d.read_byte_count      = rlen;
      result_d.read_ts_seconds      = rts[TS_W-1:20];
      result_d.read_ts_microseconds = rts[19:0];
    end
    if (commit) begin
      result_d.latest_ts_seconds      = ts_in[TS_W-1:20];
      result_d.latest_ts_microseconds = ts_in[19:0];
    end else begin
      result_d.latest_ts_seconds      = latest_q[TS_W-1:20];
      result_d.latest_ts_microseconds = latest_q[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= item_i;
      rdata_q <= payload_mem[raddr];
    end
    if (cmd_i.execute && is_write && !overflow) begin
      payload_mem[waddr] <= item_q.data_word;
    end
    if (cmd_i.execute && commit) begin
      slot_len_q[writer_slot_q] <= item_q.byte_count;
      slot_ts_q[writer_slot_q]  <= ts_in;
    end
    if (cmd_i.execute) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      writer_slot_q <= '0;
      pub_writer_q  <= '0;
      reader_slot_q <= '0;
      pub_reader_q  <= '0;
      wbc_q         <= '0;
      rbc_q         <= '0;
      wwi_q         <= '0;
      rwi_q         <= '0;
      latest_q      <= '0;
    end else if (cmd_i.execute) begin
      if (is_write) begin
        if (!item_q.word_last) begin
          if (!overflow) begin
            wwi_q <= wwi_q + WIDX_W'(1);
          end
        end else begin
          wwi_q <= '0;
          if (commit) begin
            writer_slot_q <= ws_next;
            latest_q      <= ts_in;
            if (w_publish) begin
              pub_writer_q <= ws_next;
              wbc_q        <= '0;
            end else begin
              wbc_q <= wbc_inc[BATCH_W-1:0];
            end
          end
        end
      end else if (do_read) begin
        if (rlast) begin
          rwi_q         <= '0;
          reader_slot_q <= rs_next;
          if (r_publish) begin
            pub_reader_q <= rs_next;
            rbc_q        <= '0;
          end else begin
            rbc_q <= rbc_inc[BATCH_W-1:0];
          end
        end else begin
          rwi_q <= ridx_inc[RIDX_W-1:0];
        end
      end
    end
  end

  assign result_o = result_q;

endmodule

/* sv/batched_publish_packet_ring.sv */
// an accepted beat is captured with its payload memory read, then executed into the
// registered result once the output is free; a new beat is taken only after the last
// is executed, and a waiting result holds the next beat in the datapath
// reset: asynchronous active low; pointers, batch counts, word indexes and latest
// timestamp clear, batch_size returns to 1; payload and slot stores are not cleared
`include "batched_publish_packet_ring_assert.svh"

module batched_publish_packet_ring import bpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  bpr_in_if.sink             in_i,
  bpr_out_if.source          res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [BATCH_W-1:0] batch_size_q;
  bpr_cmd_t cmd;
  item_t    item;
  result_t  result;
  logic     sel_batch;

  assign pready    = 1'b1;
  assign sel_batch = (paddr[PADDR_W-1:2] == REG_BATCH_SIZE);
  assign prdata    = sel_batch ? {{(32-BATCH_W){1'b0}}, batch_size_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_size_q <= BATCH_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && sel_batch) begin
      batch_size_q <= pwdata[BATCH_W-1:0];
    end
  end

  assign item.operation       = in_i.operation;
  assign item.data_word       = in_i.data_word;
  assign item.word_last       = in_i.word_last;
  assign item.byte_count      = in_i.byte_count;
  assign item.ts_seconds      = in_i.ts_seconds;
  assign item.ts_microseconds = in_i.ts_microseconds;

  bpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (res_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .cmd_o       (cmd)
  );

  bpr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .batch_size_i (batch_size_q),
    .item_i       (item),
    .result_o     (result)
  );

  assign res_o.status                 = result.status;
  assign res_o.read_word              = result.read_word;
  assign res_o.read_last              = result.read_last;
  assign res_o.read_byte_count        = result.read_byte_count;
  assign res_o.read_ts_seconds        = result.read_ts_seconds;
  assign res_o.read_ts_microseconds   = result.read_ts_microseconds;
  assign res_o.latest_ts_seconds      = result.latest_ts_seconds;
  assign res_o.latest_ts_microseconds = result.latest_ts_microseconds;

  `BPR_ASSERT_NEXT(a_capture_busy, clk_i, rst_ni, cmd.capture, !in_i.ready)
  `BPR_ASSERT_NEXT(a_execute_valid, clk_i, rst_ni, cmd.execute, res_o.valid)
  `BPR_ASSERT_IMPL(a_cmd_excl, clk_i, rst_ni, cmd.capture, !cmd.execute)
  `BPR_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, res_o.valid && (res_o.status == STATUS_EMPTY), (res_o.read_word == '0) && !res_o.read_last)

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpr_pkg::*;

  typedef struct {
    item_t   it;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam logic [PADDR_W-1:0] BATCH_ADDR = PADDR_W'(4 * int'(REG_BATCH_SIZE));
  localparam logic [31:0] SEC_MAX  = 32'hFFFF_FFFF;
  localparam logic [19:0] USEC_MAX = 20'd999999;
  localparam int NPHASE = 7;

  // batch setting, beats, write share, sender idle and receiver stall per phase
  int ph_batch [NPHASE] = '{0, 3, 6, 2, 5, 14, 15};
  int ph_beats [NPHASE] = '{120, 120, 120, 120, 110, 60, 50};
  int ph_wr_pct [NPHASE] = '{50, 65, 40, 55, 70, 55, 55};
  int ph_src [NPHASE] = '{0, 68, 0, 20, 0, 68, 20};
  int ph_snk [NPHASE] = '{0, 0, 68, 20, 0, 0, 20};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bpr_in_if  u_in_if ();
  bpr_out_if u_res_if ();

  batched_publish_packet_ring u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (u_in_if),
    .res_o   (u_res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ring state as the block should hold it
  logic [63:0]        word_mem [SLOTS*WORDS_PER_SLOT];
  logic [LEN_W-1:0]   len_mem [SLOTS];
  logic [TS_W-1:0]    ts_mem [SLOTS];
  logic [SLOT_W-1:0]  wr_slot = '0;
  logic [SLOT_W-1:0]  wr_pub = '0;
  logic [SLOT_W-1:0]  rd_slot = '0;
  logic [SLOT_W-1:0]  rd_pub = '0;
  logic [BATCH_W-1:0] wr_cnt = '0;
  logic [BATCH_W-1:0] rd_cnt = '0;
  logic [BATCH_W-1:0] batch_q = BATCH_SIZE_RESET;
  logic [WIDX_W-1:0]  wr_idx = '0;
  logic [RIDX_W-1:0]  rd_idx = '0;
  logic [TS_W-1:0]    latest_ts = '0;

  result_t  due_results [$];
  dir_row_t preset_q [$];
  dir_row_t dir_rows [$];
  int       fault_count = 0;
  int       beats_sent = 0;
  int       src_idle_pct = 0;
  int       snk_stall_pct = 0;
  int       hold_left = 0;

  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
    return SLOT_W'((int'(s) + 1) % SLOTS);
  endfunction

  function automatic result_t ring_predict(input item_t it);
    result_t r;
    int      idx;
    int      len;
    int      words;
    logic    last;
    r = '0;
    if (it.operation == OP_WRITE) begin
      idx = int'(wr_idx);
      if (idx < WORDS_PER_SLOT) begin
        word_mem[int'(wr_slot) * WORDS_PER_SLOT + idx] = it.data_word;
      end
      r.status = STATUS_OK;
      if (!it.word_last) begin
        if (idx < WORDS_PER_SLOT) begin
          wr_idx = wr_idx + 1'b1;
        end
      end else begin
        wr_idx = '0;
        len = int'(it.byte_count);
        if (slot_after(wr_slot) == rd_pub) begin
          r.status = STATUS_FULL;
        end else if (idx >= WORDS_PER_SLOT || len == 0 || len > MAX_BYTES ||
                     (len + 7) / 8 != idx + 1) begin
          r.status = STATUS_BAD_LEN;
        end else begin
          len_mem[wr_slot] = it.byte_count;
          ts_mem[wr_slot] = {it.ts_seconds, it.ts_microseconds};
          latest_ts = {it.ts_seconds, it.ts_microseconds};
          wr_slot = slot_after(wr_slot);
          if (int'(wr_cnt) + 1 >= int'(batch_q)) begin
            wr_pub = wr_slot;
            wr_cnt = '0;
          end else begin
            wr_cnt = wr_cnt + 1'b1;
          end
        end
      end
    end else if (rd_slot == wr_pub) begin
      r.status = STATUS_EMPTY;
    end else begin
      len = int'(len_mem[rd_slot]);
      words = (len + 7) / 8;
      if (words == 0) begin
        words = 1;
      end
      idx = int'(rd_idx);
      last = (idx + 1 >= words);
      r.status = STATUS_OK;
      r.read_word = word_mem[int'(rd_slot) * WORDS_PER_SLOT + idx];
      r.read_last = last;
      r.read_byte_count = len_mem[rd_slot];
      r.read_ts_seconds = ts_mem[rd_slot][51:20];
      r.read_ts_microseconds = ts_mem[rd_slot][19:0];
      if (last) begin
        rd_idx = '0;
        rd_slot = slot_after(rd_slot);
        if (int'(rd_cnt) + 1 > int'(batch_q)) begin
          rd_pub = rd_slot;
          rd_cnt = '0;
        end else begin
          rd_cnt = rd_cnt + 1'b1;
        end
      end else begin
        rd_idx = rd_idx + 1'b1;
      end
    end
    r.latest_ts_seconds = latest_ts[51:20];
    r.latest_ts_microseconds = latest_ts[19:0];
    return r;
  endfunction

  function automatic logic differs(input result_t a, input result_t b);
    return a.status !== b.status || a.read_word !== b.read_word ||
           a.read_last !== b.read_last || a.read_byte_count !== b.read_byte_count ||
           a.read_ts_seconds !== b.read_ts_seconds ||
           a.read_ts_microseconds !== b.read_ts_microseconds ||
           a.latest_ts_seconds !== b.latest_ts_seconds ||
           a.latest_ts_microseconds !== b.latest_ts_microseconds;
  endfunction

  function automatic void log_fault(input string why, input result_t want, input result_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s exp: st=%0d word=%h last=%0b len=%0d ts=%h.%h latest=%h.%h", why,
               want.status, want.read_word, want.read_last, want.read_byte_count,
               want.read_ts_seconds, want.read_ts_microseconds,
               want.latest_ts_seconds, want.latest_ts_microseconds);
      $display("%s got: st=%0d word=%h last=%0b len=%0d ts=%h.%h latest=%h.%h", why,
               got.status, got.read_word, got.read_last, got.read_byte_count,
               got.read_ts_seconds, got.read_ts_microseconds,
               got.latest_ts_seconds, got.latest_ts_microseconds);
    end
  endfunction

  function automatic item_t noisy_item();
    item_t it;
    it.operation = OP_READ;
    it.data_word = {$urandom, $urandom};
    it.word_last = 1'($urandom);
    it.byte_count = LEN_W'($urandom);
    it.ts_seconds = $urandom;
    it.ts_microseconds = 20'($urandom);
    return it;
  endfunction

  function automatic item_t wr_item(input logic [63:0] data, input logic last,
                                    input logic [LEN_W-1:0] len, input logic [31:0] sec,
                                    input logic [19:0] usec);
    return '{OP_WRITE, data, last, len, sec, usec};
  endfunction

  function automatic result_t quiet(input logic [1:0] st, input logic [31:0] sec,
                                    input logic [19:0] usec);
    result_t r;
    r = '0;
    r.status = st;
    r.latest_ts_seconds = sec;
    r.latest_ts_microseconds = usec;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side, with a long hold-off when asked
  initial begin
    u_res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        u_res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        u_res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t  got;
    result_t  want;
    item_t    it;
    dir_row_t row;
    if (u_res_if.valid && u_res_if.ready) begin
      got = '{u_res_if.status, u_res_if.read_word, u_res_if.read_last,
              u_res_if.read_byte_count, u_res_if.read_ts_seconds,
              u_res_if.read_ts_microseconds, u_res_if.latest_ts_seconds,
              u_res_if.latest_ts_microseconds};
      if (due_results.size() == 0) begin
        log_fault("unexpected beat", '0, got);
      end else begin
        want = due_results.pop_front();
        if (differs(want, got)) begin
          log_fault("mismatch", want, got);
        end
      end
    end
    if (rst_ni && u_in_if.valid && u_in_if.ready) begin
      it = '{u_in_if.operation, u_in_if.data_word, u_in_if.word_last, u_in_if.byte_count,
             u_in_if.ts_seconds, u_in_if.ts_microseconds};
      want = ring_predict(it);
      if (preset_q.size() != 0) begin
        row = preset_q.pop_front();
        if (row.typed) begin
          want = row.want;
        end
      end
      due_results.push_back(want);
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      u_in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    u_in_if.valid <= 1'b1;
    u_in_if.operation <= it.operation;
    u_in_if.data_word <= it.data_word;
    u_in_if.word_last <= it.word_last;
    u_in_if.byte_count <= it.byte_count;
    u_in_if.ts_seconds <= it.ts_seconds;
    u_in_if.ts_microseconds <= it.ts_microseconds;
    do @(posedge clk_i); while (!u_in_if.ready);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    u_in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == BATCH_ADDR) begin
      batch_q = data[BATCH_W-1:0];
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly well formed packets, some with a wrong length or too many words
  task automatic send_packet();
    int               n;
    int               pick;
    logic [LEN_W-1:0] len;
    item_t            it;
    pick = $urandom_range(99);
    if (pick < 75) n = $urandom_range(4, 1);
    else if (pick < 88) n = $urandom_range(16, 5);
    else if (pick < 93) n = $urandom_range(31, 17);
    else if (pick < 97) n = WORDS_PER_SLOT;
    else n = $urandom_range(WORDS_PER_SLOT + 3, WORDS_PER_SLOT + 1);
    if (n == WORDS_PER_SLOT && $urandom_range(1) == 0) len = LEN_W'(MAX_BYTES);
    else if (n <= WORDS_PER_SLOT && $urandom_range(99) < 85)
      len = LEN_W'($urandom_range(8 * n, 8 * n - 7));
    else len = LEN_W'($urandom_range(511));
    for (int k = 0; k < n; k++) begin
      it = noisy_item();
      it.operation = OP_WRITE;
      it.word_last = (k == n - 1);
      if (it.word_last) begin
        it.byte_count = len;
        if ($urandom_range(9) != 0) it.ts_microseconds = 20'($urandom_range(999999));
      end
      send_item(it);
    end
  endtask

  task automatic read_burst();
    item_t it;
    repeat ($urandom_range(8, 1)) begin
      it = noisy_item();
      send_item(it);
    end
  endtask

  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    u_in_if.valid = 1'b0;
    u_in_if.operation = OP_WRITE;
    u_in_if.data_word = '0;
    u_in_if.word_last = 1'b0;
    u_in_if.byte_count = '0;
    u_in_if.ts_seconds = '0;
    u_in_if.ts_microseconds = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows = '{
      '{noisy_item(), 1'b1, quiet(STATUS_EMPTY, '0, '0)},
      '{wr_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 9'd8, SEC_MAX, USEC_MAX), 1'b1,
        quiet(STATUS_OK, SEC_MAX, USEC_MAX)},
      '{noisy_item(), 1'b0, '0},
      // zero, oversized and all-ones lengths
      '{wr_item('0, 1'b1, 9'd0, '0, '0), 1'b1, quiet(STATUS_BAD_LEN, SEC_MAX, USEC_MAX)},
      '{wr_item('0, 1'b1, 9'd300, '0, '0), 1'b1, quiet(STATUS_BAD_LEN, SEC_MAX, USEC_MAX)},
      '{wr_item('0, 1'b1, 9'd511, '0, '0), 1'b1, quiet(STATUS_BAD_LEN, SEC_MAX, USEC_MAX)},
      // two words written, three needed
      '{wr_item(64'h0123_4567_89AB_CDEF, 1'b0, 9'h1FF, SEC_MAX, 20'hFFFFF), 1'b0, '0},
      '{wr_item(64'hFEDC_BA98_7654_3210, 1'b1, 9'd17, 32'd1, 20'd1), 1'b1,
        quiet(STATUS_BAD_LEN, SEC_MAX, USEC_MAX)},
      '{wr_item(64'h5555_5555_5555_5555, 1'b0, '0, '0, '0), 1'b0, '0},
      '{wr_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 9'd16, '0, '0), 1'b1,
        quiet(STATUS_OK, '0, '0)},
      // microseconds beyond range kept as given
      '{wr_item(64'h8000_0000_0000_0001, 1'b1, 9'd1, 32'h8000_0000, 20'hFFFFF), 1'b1,
        quiet(STATUS_OK, 32'h8000_0000, 20'hFFFFF)},
      // tail bytes past the length stay unmasked
      '{wr_item(64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 9'd3, 32'h1234_5678, '0), 1'b0, '0},
      '{noisy_item(), 1'b0, '0},
      '{noisy_item(), 1'b0, '0},
      '{noisy_item(), 1'b0, '0},
      '{noisy_item(), 1'b0, '0},
      '{noisy_item(), 1'b1, quiet(STATUS_EMPTY, 32'h1234_5678, '0)}
    };
    foreach (dir_rows[k]) begin
      preset_q.push_back(dir_rows[k]);
      send_item(dir_rows[k].it);
    end
    wait_drained();

    for (int p = 0; p < NPHASE; p++) begin
      cfg_write(BATCH_ADDR, {(32 - BATCH_W)'($urandom), BATCH_W'(ph_batch[p])});
      src_idle_pct = ph_src[p];
      snk_stall_pct = ph_snk[p];
      if (p == 0) begin
        hold_left = 300;
      end
      beats_sent = 0;
      while (beats_sent < ph_beats[p]) begin
        if ($urandom_range(99) < ph_wr_pct[p]) send_packet();
        else read_burst();
      end
      wait_drained();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
